>>> sv/octave_value_noise_height_macros.svh
// ----------------------------------------------------------------------------
// Octave value noise height: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_VALUE_NOISE_HEIGHT_MACROS_SVH
`define OCTAVE_VALUE_NOISE_HEIGHT_MACROS_SVH

// Same-cycle implication.
`define OVNH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OVNH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ovnh_pkg.sv
// ----------------------------------------------------------------------------
// ovnh_pkg
// Types, register indexes, constants and the weight table function shared by
// the octave value noise height block.
// ----------------------------------------------------------------------------
`default_nettype none

package ovnh_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_SEED       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OCTAVES    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHNESS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ROUGHNESS  = 3'd5;

  localparam logic [31:0] RST_SEED       = 32'd0;
  localparam logic [4:0]  RST_OCTAVES    = 5'd7;
  localparam logic [9:0]  RST_AMPLITUDE  = 10'd70;
  localparam logic [15:0] RST_SMOOTHNESS = 16'd235;
  localparam logic [10:0] RST_OFFSET     = 11'd0;
  localparam logic [15:0] RST_ROUGHNESS  = 16'd34734;

  localparam logic [21:0] HEIGHT_MAX   = 22'd4194303;
  localparam logic [21:0] HEIGHT_WATER = 22'd16128;
  localparam logic [21:0] HEIGHT_FLOOR = 22'd256;

  localparam logic [31:0] HASH_ROW     = 32'd57;
  localparam logic [31:0] HASH_MUL     = 32'd60493;
  localparam logic [31:0] HASH_ADD1    = 32'd19990303;
  localparam logic [31:0] HASH_ADD2    = 32'd1376312589;
  localparam logic signed [31:0] NOISE_ONE = 32'sh40000000;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  // 126 * 2^30, 105 * 2^21 and 105 * 2^22.
  localparam logic signed [55:0] NORM_OFFSET = 56'sd135291469824;
  localparam logic signed [55:0] NORM_ROUND  = 56'sd220200960;
  localparam logic [29:0]        NORM_BIAS   = 30'd440401920;
  // ceil(2^37 / 105): exact floor division by 105 for any 30-bit dividend.
  localparam logic [30:0]        NORM_RECIP  = 31'd1308942415;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_COORD,
    OP_DIV_FRAC,
    OP_WEIGHT,
    OP_H0,
    OP_H1,
    OP_H2,
    OP_H3,
    OP_H4,
    OP_BDIFF,
    OP_BMIX,
    OP_TERM,
    OP_ACC,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_FIN4,
    OP_PUB
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic more;
    logic div_busy;
    logic out_full;
  } status_t;

  typedef struct packed {
    logic [31:0]        seed;
    logic [4:0]         octave_count;
    logic [9:0]         amplitude;
    logic [15:0]        smoothness;
    logic signed [10:0] height_offset;
    logic [15:0]        roughness;
  } cfg_t;

  // Blend weight (1 - cos(theta)) / 2 in Q1.16 from a Q30 Taylor series.
  function automatic logic [16:0] cos_weight(input logic [63:0] th);
    logic [63:0] th2;
    logic [63:0] term;
    longint      c;
    longint      w;
    th2  = (th * th) >> 36;
    term = 64'd1 << 30;
    c    = longint'(64'd1 << 30);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * th2) >> 24) / 64'((2 * k - 1) * (2 * k));
      if (k[0]) begin
        c = c - longint'(term);
      end else begin
        c = c + longint'(term);
      end
    end
    w = longint'(64'd1 << 30) - c + longint'(64'd1 << 14);
    if (w < 0) begin
      return 17'd0;
    end
    w = w >>> 15;
    if (w > 65536) begin
      return WEIGHT_ONE;
    end
    return 17'(w);
  endfunction

endpackage

`default_nettype wire

>>> sv/octave_value_noise_height.sv
// ----------------------------------------------------------------------------
// octave_value_noise_height
// Terrain height of one column from octaves of seeded value noise.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  local_x, local_z, chunk_x, chunk_z
//   m_axis    out  m_axis_tvalid/m_axis_tready  height_q8, outside_world (tuser)
//   cfg       in   cfg_we_i                     register index and write data
//
// One column is in flight at a time. With K = max(min(octave_count, MAX_OCTAVES) - 1, 0)
// octaves, the time from a column's accepting edge until the next beat can be taken is
// set by the bit-serial smoothness dividers (coordinate and fraction per octave) and the
// shared hash unit. A column outside the world skips the octave loop. The result waits
// in an output register, so a stalled m_axis only holds the next result at its publish
// step. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module octave_value_noise_height #(
  parameter int CHUNK_WIDTH        = 16,
  parameter int MAX_OCTAVES        = 16,
  parameter int WEIGHT_TABLE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // local_x[3:0], local_z[7:4], chunk_x[23:8], chunk_z[39:24]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // height_q8[21:0], zero fill[23:22]
  output logic [23:0]      m_axis_tdata,
  // outside_world[0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [ovnh_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ovnh_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ovnh_pkg::cfg_t    cfg_q;
  ovnh_pkg::cmd_t    cmd;
  ovnh_pkg::status_t status;
  logic [21:0]       height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed          <= ovnh_pkg::RST_SEED;
      cfg_q.octave_count  <= ovnh_pkg::RST_OCTAVES;
      cfg_q.amplitude     <= ovnh_pkg::RST_AMPLITUDE;
      cfg_q.smoothness    <= ovnh_pkg::RST_SMOOTHNESS;
      cfg_q.height_offset <= ovnh_pkg::RST_OFFSET;
      cfg_q.roughness     <= ovnh_pkg::RST_ROUGHNESS;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ovnh_pkg::REG_SEED:       cfg_q.seed          <= cfg_wdata_i;
        ovnh_pkg::REG_OCTAVES:    cfg_q.octave_count  <= cfg_wdata_i[4:0];
        ovnh_pkg::REG_AMPLITUDE:  cfg_q.amplitude     <= cfg_wdata_i[9:0];
        ovnh_pkg::REG_SMOOTHNESS: cfg_q.smoothness    <= cfg_wdata_i[15:0];
        ovnh_pkg::REG_OFFSET:     cfg_q.height_offset <= $signed(cfg_wdata_i[10:0]);
        ovnh_pkg::REG_ROUGHNESS:  cfg_q.roughness     <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  ovnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ovnh_datapath #(
    .CHUNK_WIDTH        (CHUNK_WIDTH),
    .MAX_OCTAVES        (MAX_OCTAVES),
    .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg_q),
    .local_x_i     (s_axis_tdata[3:0]),
    .local_z_i     (s_axis_tdata[7:4]),
    .chunk_x_i     ($signed(s_axis_tdata[23:8])),
    .chunk_z_i     ($signed(s_axis_tdata[39:24])),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_height_o  (height),
    .out_outside_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, height};

endmodule

`default_nettype wire

>>> sv/ovnh_div.sv
// ----------------------------------------------------------------------------
// ovnh_div
// Restoring divider, one quotient bit per cycle, for unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ovnh_div #(
  parameter int DIV_W = 48,
  parameter int DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [DIV_W-1:0]      quotient_o,
  output logic [DEN_W-1:0]      remainder_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

>>> sv/ovnh_datapath.sv
// ----------------------------------------------------------------------------
// ovnh_datapath
// Coordinate dividers, weight table, hash unit, blend unit, octave
// accumulator, normalization and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ovnh_datapath #(
  parameter int CHUNK_WIDTH        = 16,
  parameter int MAX_OCTAVES        = 16,
  parameter int WEIGHT_TABLE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ovnh_pkg::cmd_t     cmd_i,
  output ovnh_pkg::status_t       status_o,
  input  wire ovnh_pkg::cfg_t     cfg_i,
  input  wire logic [3:0]         local_x_i,
  input  wire logic [3:0]         local_z_i,
  input  wire logic signed [15:0] chunk_x_i,
  input  wire logic signed [15:0] chunk_z_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [21:0]             out_height_o,
  output logic                    out_outside_o
);

  localparam int PX_W   = 32 + MAX_OCTAVES;
  localparam int DIV_W  = PX_W;
  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int TAB_AW = $clog2(WEIGHT_TABLE_DEPTH);
  localparam logic signed [31:0] CW_S = 32'(CHUNK_WIDTH);

  // Constant blend weight table.
  logic [16:0] wtab [WEIGHT_TABLE_DEPTH];
  for (genvar gi = 0; gi < WEIGHT_TABLE_DEPTH; gi++) begin : g_wtab
    localparam logic [63:0] TH =
      ((64'd314 * 64'(gi)) << 30) / (64'd100 * 64'(WEIGHT_TABLE_DEPTH));
    assign wtab[gi] = ovnh_pkg::cos_weight(TH);
  end

  logic [30:0]        wx_q, wz_q;
  logic               outside_q;
  logic [OCT_W-1:0]   oct_q;
  logic [16:0]        r_q;
  logic signed [35:0] sum_q;
  logic [31:0]        ix_q, iz_q;
  logic [16:0]        fx_q, fz_q;
  logic [31:0]        n_q, t_q;
  logic signed [31:0] corner_q [4];
  logic signed [32:0] diff_q;
  logic signed [31:0] r1_q, r2_q, nz_q;
  logic signed [49:0] prod_q;
  logic signed [55:0] fin_q;
  logic [23:0]        norm_q;
  logic [21:0]        res_h_q;
  logic               res_out_q;
  logic               out_valid_q;
  logic [21:0]        out_h_q;
  logic               out_flag_q;

  // World coordinates.
  logic signed [31:0] wx_s, wz_s;
  assign wx_s = 32'(chunk_x_i) * CW_S + $signed({28'd0, local_x_i});
  assign wz_s = 32'(chunk_z_i) * CW_S + $signed({28'd0, local_z_i});

  // Octave limit and loop status.
  logic [5:0] oct_lim;
  logic       more;
  assign oct_lim = ({1'b0, cfg_i.octave_count} > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES)
                                                                 : {1'b0, cfg_i.octave_count};
  assign more = ((7'(oct_q) + 7'd1) < {1'b0, oct_lim});

  logic [15:0] sm;
  assign sm = (cfg_i.smoothness == 16'd0) ? 16'd1 : cfg_i.smoothness;

  // Dividers.
  logic             dx_start, dz_start, dx_busy, dz_busy;
  logic [DIV_W-1:0] dx_dividend, dz_dividend, dx_quo, dz_quo;
  logic [15:0]      den, dx_rem, dz_rem;

  // The normalized value stays well inside 29 signed bits. A bias of 105 * 2^22
  // makes it positive, so the division by 105 is a reciprocal multiplication and
  // the quotient carries an offset of 2^22.
  logic signed [29:0] norm_y;
  logic [29:0]        norm_biased;
  logic [60:0]        norm_prod;

  assign norm_y      = $signed(fin_q[51:22]);
  assign norm_biased = $unsigned(norm_y) + ovnh_pkg::NORM_BIAS;
  assign norm_prod   = 61'(norm_biased) * 61'(ovnh_pkg::NORM_RECIP);

  always_comb begin
    dx_start    = 1'b0;
    dz_start    = 1'b0;
    dx_dividend = '0;
    dz_dividend = '0;
    den         = sm;
    case (cmd_i.op)
      ovnh_pkg::OP_DIV_COORD: begin
        dx_start    = 1'b1;
        dz_start    = 1'b1;
        dx_dividend = DIV_W'(wx_q) << oct_q;
        dz_dividend = DIV_W'(wz_q) << oct_q;
      end
      ovnh_pkg::OP_DIV_FRAC: begin
        dx_start    = 1'b1;
        dz_start    = 1'b1;
        dx_dividend = DIV_W'(dx_rem) * DIV_W'(WEIGHT_TABLE_DEPTH);
        dz_dividend = DIV_W'(dz_rem) * DIV_W'(WEIGHT_TABLE_DEPTH);
      end
      default: begin
      end
    endcase
  end

  ovnh_div #(.DIV_W(DIV_W), .DEN_W(16)) u_div_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dx_start),
    .dividend_i  (dx_dividend),
    .divisor_i   (den),
    .busy_o      (dx_busy),
    .quotient_o  (dx_quo),
    .remainder_o (dx_rem)
  );

  ovnh_div #(.DIV_W(DIV_W), .DEN_W(16)) u_div_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dz_start),
    .dividend_i  (dz_dividend),
    .divisor_i   (den),
    .busy_o      (dz_busy),
    .quotient_o  (dz_quo),
    .remainder_o (dz_rem)
  );

  // Hash unit inputs: corner offset comes from the command index.
  logic [31:0] hx, hz, n0, n_mix, sq, t_mul, t_fin;
  assign hx    = ix_q + {31'd0, cmd_i.idx[0]};
  assign hz    = iz_q + {31'd0, cmd_i.idx[1]};
  assign n0    = hx + hz * ovnh_pkg::HASH_ROW + cfg_i.seed;
  assign n_mix = n0 ^ (n0 << 13);
  assign sq    = n_q * n_q;
  assign t_mul = t_q * ovnh_pkg::HASH_MUL + ovnh_pkg::HASH_ADD1;
  assign t_fin = n_q * t_q + ovnh_pkg::HASH_ADD2;

  // Blend unit: a + (b - a) * w, rounded, floor of the Q16 result.
  logic signed [31:0] blend_a, blend_b;
  logic [16:0]        blend_w;
  logic signed [17:0] w_s;
  logic signed [51:0] mix_full;

  always_comb begin
    case (cmd_i.idx)
      2'd0: begin
        blend_a = corner_q[0];
        blend_b = corner_q[1];
        blend_w = fx_q;
      end
      2'd1: begin
        blend_a = corner_q[2];
        blend_b = corner_q[3];
        blend_w = fx_q;
      end
      default: begin
        blend_a = r1_q;
        blend_b = r2_q;
        blend_w = fz_q;
      end
    endcase
  end

  assign w_s      = $signed({1'b0, blend_w});
  assign mix_full = (52'(blend_a) <<< 16) + 52'(diff_q) * 52'(w_s) + 52'sd32768;

  // Octave term, weight update and normalization.
  logic signed [49:0] term_full;
  logic [33:0]        r_next;
  logic signed [55:0] sum_ext;
  logic signed [55:0] norm_f;
  logic signed [55:0] norm_g;
  logic signed [39:0] h_s;
  logic [21:0]        h_clamped;

  assign term_full = 50'(nz_q) * 50'($signed({1'b0, r_q})) + 50'sd32768;
  assign r_next    = 34'(r_q) * 34'(cfg_i.roughness) + 34'd32768;
  assign sum_ext   = 56'(sum_q);
  assign norm_f    = (sum_ext <<< 5) + (sum_ext <<< 4) + (sum_ext <<< 1)
                     + ovnh_pkg::NORM_OFFSET;
  assign norm_g    = fin_q * 56'($signed({1'b0, cfg_i.amplitude})) + ovnh_pkg::NORM_ROUND;
  assign h_s       = $signed({16'd0, norm_q}) - 40'sd4194304
                     + (40'(cfg_i.height_offset) <<< 8);

  always_comb begin
    if (h_s <= 40'sd0) begin
      h_clamped = ovnh_pkg::HEIGHT_FLOOR;
    end else if (h_s > 40'(ovnh_pkg::HEIGHT_MAX)) begin
      h_clamped = ovnh_pkg::HEIGHT_MAX;
    end else begin
      h_clamped = h_s[21:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ovnh_pkg::OP_LOAD: begin
        wx_q      <= wx_s[30:0];
        wz_q      <= wz_s[30:0];
        outside_q <= wx_s[31] | wz_s[31];
        oct_q     <= '0;
        r_q       <= ovnh_pkg::WEIGHT_ONE;
        sum_q     <= '0;
        res_h_q   <= ovnh_pkg::HEIGHT_WATER;
        res_out_q <= 1'b1;
      end
      ovnh_pkg::OP_DIV_FRAC: begin
        ix_q <= dx_quo[31:0];
        iz_q <= dz_quo[31:0];
      end
      ovnh_pkg::OP_WEIGHT: begin
        fx_q <= wtab[dx_quo[TAB_AW-1:0]];
        fz_q <= wtab[dz_quo[TAB_AW-1:0]];
      end
      ovnh_pkg::OP_H0: n_q <= n_mix;
      ovnh_pkg::OP_H1: t_q <= sq;
      ovnh_pkg::OP_H2: t_q <= t_mul;
      ovnh_pkg::OP_H3: t_q <= t_fin;
      ovnh_pkg::OP_H4: begin
        corner_q[cmd_i.idx] <= ovnh_pkg::NOISE_ONE - $signed({1'b0, t_q[30:0]});
      end
      ovnh_pkg::OP_BDIFF: diff_q <= 33'(blend_b) - 33'(blend_a);
      ovnh_pkg::OP_BMIX: begin
        case (cmd_i.idx)
          2'd0:    r1_q <= mix_full[47:16];
          2'd1:    r2_q <= mix_full[47:16];
          default: nz_q <= mix_full[47:16];
        endcase
      end
      ovnh_pkg::OP_TERM: prod_q <= term_full;
      ovnh_pkg::OP_ACC: begin
        sum_q <= sum_q + 36'($signed(prod_q[49:16]));
        r_q   <= r_next[32:16];
        oct_q <= oct_q + 1'b1;
      end
      ovnh_pkg::OP_FIN1: fin_q <= norm_f;
      ovnh_pkg::OP_FIN2: fin_q <= norm_g;
      ovnh_pkg::OP_FIN3: norm_q <= norm_prod[60:37];
      ovnh_pkg::OP_FIN4: begin
        res_h_q   <= h_clamped;
        res_out_q <= 1'b0;
      end
      ovnh_pkg::OP_PUB: begin
        out_h_q    <= res_h_q;
        out_flag_q <= res_out_q;
      end
      default: begin
      end
    endcase
  end

  // Output slot: the controller publishes only into an empty slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == ovnh_pkg::OP_PUB) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.outside  = outside_q;
  assign status_o.more     = more;
  assign status_o.div_busy = dx_busy | dz_busy;
  assign status_o.out_full = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign out_height_o  = out_h_q;
  assign out_outside_o = out_flag_q;

endmodule

`default_nettype wire

>>> sv/ovnh_ctrl.sv
// ----------------------------------------------------------------------------
// ovnh_ctrl
// Sequencer: steps the datapath through load, per-octave division, hashing,
// blending and accumulation, then normalization and publish; a column outside the world goes straight to publish.
// ----------------------------------------------------------------------------
`default_nettype none
`include "octave_value_noise_height_macros.svh"

module ovnh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire ovnh_pkg::status_t status_i,
  output ovnh_pkg::cmd_t         cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CHECK = 5'd1;
  localparam logic [4:0] ST_DIVC  = 5'd2;
  localparam logic [4:0] ST_DIVCW = 5'd3;
  localparam logic [4:0] ST_DIVF  = 5'd4;
  localparam logic [4:0] ST_DIVFW = 5'd5;
  localparam logic [4:0] ST_WGT   = 5'd6;
  localparam logic [4:0] ST_H0    = 5'd7;
  localparam logic [4:0] ST_H1    = 5'd8;
  localparam logic [4:0] ST_H2    = 5'd9;
  localparam logic [4:0] ST_H3    = 5'd10;
  localparam logic [4:0] ST_H4    = 5'd11;
  localparam logic [4:0] ST_BD    = 5'd12;
  localparam logic [4:0] ST_BM    = 5'd13;
  localparam logic [4:0] ST_TERM  = 5'd14;
  localparam logic [4:0] ST_ACC   = 5'd15;
  localparam logic [4:0] ST_FIN1  = 5'd16;
  localparam logic [4:0] ST_FIN2  = 5'd17;
  localparam logic [4:0] ST_FIN3  = 5'd18;
  localparam logic [4:0] ST_FIN4  = 5'd20;
  localparam logic [4:0] ST_PUB   = 5'd21;

  logic [4:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    s_tready_o = 1'b0;
    cmd_o.op   = ovnh_pkg::OP_NONE;
    cmd_o.idx  = idx_q;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = ovnh_pkg::OP_LOAD;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.outside) begin
          state_d = ST_PUB;
        end else if (status_i.more) begin
          state_d = ST_DIVC;
        end else begin
          state_d = ST_FIN1;
        end
      end
      ST_DIVC: begin
        cmd_o.op = ovnh_pkg::OP_DIV_COORD;
        state_d  = ST_DIVCW;
      end
      ST_DIVCW: if (!status_i.div_busy) state_d = ST_DIVF;
      ST_DIVF: begin
        cmd_o.op = ovnh_pkg::OP_DIV_FRAC;
        state_d  = ST_DIVFW;
      end
      ST_DIVFW: if (!status_i.div_busy) state_d = ST_WGT;
      ST_WGT: begin
        cmd_o.op = ovnh_pkg::OP_WEIGHT;
        idx_d    = 2'd0;
        state_d  = ST_H0;
      end
      ST_H0: begin
        cmd_o.op = ovnh_pkg::OP_H0;
        state_d  = ST_H1;
      end
      ST_H1: begin
        cmd_o.op = ovnh_pkg::OP_H1;
        state_d  = ST_H2;
      end
      ST_H2: begin
        cmd_o.op = ovnh_pkg::OP_H2;
        state_d  = ST_H3;
      end
      ST_H3: begin
        cmd_o.op = ovnh_pkg::OP_H3;
        state_d  = ST_H4;
      end
      ST_H4: begin
        cmd_o.op = ovnh_pkg::OP_H4;
        if (idx_q == 2'd3) begin
          idx_d   = 2'd0;
          state_d = ST_BD;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_H0;
        end
      end
      ST_BD: begin
        cmd_o.op = ovnh_pkg::OP_BDIFF;
        state_d  = ST_BM;
      end
      ST_BM: begin
        cmd_o.op = ovnh_pkg::OP_BMIX;
        if (idx_q == 2'd2) begin
          state_d = ST_TERM;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_BD;
        end
      end
      ST_TERM: begin
        cmd_o.op = ovnh_pkg::OP_TERM;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = ovnh_pkg::OP_ACC;
        state_d  = ST_CHECK;
      end
      ST_FIN1: begin
        cmd_o.op = ovnh_pkg::OP_FIN1;
        state_d  = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.op = ovnh_pkg::OP_FIN2;
        state_d  = ST_FIN3;
      end
      ST_FIN3: begin
        cmd_o.op = ovnh_pkg::OP_FIN3;
        state_d  = ST_FIN4;
      end
      ST_FIN4: begin
        cmd_o.op = ovnh_pkg::OP_FIN4;
        state_d  = ST_PUB;
      end
      ST_PUB: begin
        // Hold the result until the output slot has drained.
        if (!status_i.out_full) begin
          cmd_o.op = ovnh_pkg::OP_PUB;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `OVNH_ASSERT_IMP(a_pub_slot_free, cmd_o.op == ovnh_pkg::OP_PUB, !status_i.out_full, "publish into a full output slot")
  `OVNH_ASSERT_NXT(a_div_started, state_q == ST_DIVC || state_q == ST_DIVF, status_i.div_busy, "divider did not start")
  `OVNH_ASSERT_IMP(a_blend_idx, state_q == ST_BD || state_q == ST_BM, idx_q != 2'd3, "blend step index out of range")
  `OVNH_ASSERT_NXT(a_accept_check, s_tvalid_i && s_tready_o, state_q == ST_CHECK, "accepted beat not followed by check")

endmodule

`default_nettype wire

>>> sim/octave_value_noise_height_tb.sv
// ----------------------------------------------------------------------------
// octave_value_noise_height_tb
// Self-checking bench for the octave value noise height block. A directed
// table of columns and register settings comes first, then random columns
// under several register settings. Every result beat is compared with a
// height predicted in the bench itself.
// ----------------------------------------------------------------------------
`default_nettype none

module octave_value_noise_height_tb;
  import ovnh_pkg::*;

  localparam int CHUNK_W    = 16;
  localparam int OCT_MAX    = 16;
  localparam int TAB_DEPTH  = 256;
  localparam int RAND_ITEMS = 1750;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [21:0] height;
    logic        outside;
  } column_res_t;

  typedef struct {
    logic [3:0]  lx;
    logic [3:0]  lz;
    logic [15:0] cx;
    logic [15:0] cz;
    bit          known;
    logic [21:0] height;
  } column_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  octave_value_noise_height uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers.
  logic [31:0] sh_seed;
  logic [4:0]  sh_octaves;
  logic [9:0]  sh_amp;
  logic [15:0] sh_smooth;
  logic [10:0] sh_offset;
  logic [15:0] sh_rough;

  logic [16:0] blend_tab [TAB_DEPTH];
  column_res_t heights_due[$];
  int errors = 0;
  int results_seen = 0;
  int outside_seen = 0;
  longint cycles = 0;
  bit calm = 1'b0;

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic void build_blend_tab();
    logic [63:0] th, th2, term;
    longint c, w;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      th   = ((64'd314 * i) << 30) / (64'd100 * TAB_DEPTH);
      th2  = (th * th) >> 36;
      term = 64'd1 << 30;
      c    = 64'sd1 << 30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * th2) >> 24) / 64'((2 * k - 1) * (2 * k));
        if (k % 2 == 1) c = c - longint'(term);
        else c = c + longint'(term);
      end
      w = floor_div((64'sd1 << 30) - c + (64'sd1 << 14), 64'sd1 << 15);
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
      blend_tab[i] = 17'(w);
    end
  endfunction

  function automatic longint lattice_value(logic [31:0] ix, logic [31:0] iz);
    logic [31:0] n, m;
    n = ix + iz * 32'd57 + sh_seed;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
    return (64'sd1 << 30) - longint'({32'd0, m});
  endfunction

  function automatic longint cos_lerp(longint a, longint b, logic [16:0] w);
    return floor_div(a * (65536 - longint'(w)) + b * longint'(w) + 32768, 65536);
  endfunction

  function automatic column_res_t column_height(logic [3:0] lx, logic [3:0] lz,
                                                logic [15:0] cx, logic [15:0] cz);
    column_res_t res;
    longint wx, wz, sum, r, sm, px, pz, r1, r2, nz, h;
    longint fx, fz;
    logic [31:0] ix, iz;
    int cnt;
    wx = longint'(lx) + longint'($signed(cx)) * CHUNK_W;
    wz = longint'(lz) + longint'($signed(cz)) * CHUNK_W;
    if (wx < 0 || wz < 0) begin
      res.height = 22'(63 * 256);
      res.outside = 1'b1;
      return res;
    end
    cnt = (sh_octaves > OCT_MAX) ? OCT_MAX : int'(sh_octaves);
    sm  = (sh_smooth == 0) ? 1 : longint'(sh_smooth);
    sum = 0;
    r   = 65536;
    for (int a = 0; a + 1 < cnt; a++) begin
      px = wx << a;
      pz = wz << a;
      ix = 32'(px / sm);
      iz = 32'(pz / sm);
      fx = blend_tab[((px % sm) * TAB_DEPTH) / sm];
      fz = blend_tab[((pz % sm) * TAB_DEPTH) / sm];
      r1 = cos_lerp(lattice_value(ix, iz), lattice_value(ix + 1, iz), 17'(fx));
      r2 = cos_lerp(lattice_value(ix, iz + 1), lattice_value(ix + 1, iz + 1), 17'(fx));
      nz = cos_lerp(r1, r2, 17'(fz));
      sum += floor_div(nz * r + 32768, 65536);
      r = (r * longint'(sh_rough) + 32768) >> 16;
    end
    h = floor_div((50 * sum + 126 * (64'sd1 << 30)) * longint'(sh_amp)
                  + 105 * (64'sd1 << 21), 105 * (64'sd1 << 22));
    h += longint'($signed(sh_offset)) * 256;
    if (h <= 0) h = 256;
    if (h > 4194303) h = 4194303;
    res.height = 22'(h);
    res.outside = 1'b0;
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SEED:       sh_seed = val;
      REG_OCTAVES:    sh_octaves = val[4:0];
      REG_AMPLITUDE:  sh_amp = val[9:0];
      REG_SMOOTHNESS: sh_smooth = val[15:0];
      REG_OFFSET:     sh_offset = val[10:0];
      REG_ROUGHNESS:  sh_rough = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk_i);
    // Every column gives a result, so an empty queue means the block is idle.
    repeat (4) @(posedge clk_i);
  endtask

  // Valid stays high after a beat is taken, so the next column can follow at
  // once; it drops only for an idle burst or when the stream is drained.
  task automatic send_column(input logic [3:0] lx, input logic [3:0] lz,
                             input logic [15:0] cx, input logic [15:0] cz);
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cz, cx, lz, lx};
    heights_due.push_back(column_height(lx, lz, cx, cz));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Receiver: checks each result beat here; the block below makes random stall bursts, then ready.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      column_res_t want;
      results_seen++;
      if (m_axis_tuser) outside_seen++;
      if (heights_due.size() == 0) begin
        $display("%0t: unexpected result beat height=%0d outside=%0b",
                 $time, m_axis_tdata[21:0], m_axis_tuser);
        errors++;
      end else begin
        want = heights_due.pop_front();
        if (m_axis_tdata[21:0] !== want.height || m_axis_tdata[23:22] !== 2'b00) begin
          $display("%0t: height expected %0d actual %0d", $time, want.height,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.outside) begin
          $display("%0t: outside_world expected %0b actual %0b", $time,
                   want.outside, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(5) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  column_row_t directed[] = '{
    '{4'd0, 4'd0, 16'h0000, 16'h0000, 1'b0, 22'd0},
    '{4'd15, 4'd15, 16'h7fff, 16'h7fff, 1'b0, 22'd0},
    '{4'd0, 4'd0, 16'hffff, 16'h0000, 1'b1, 22'd16128},
    '{4'd15, 4'd15, 16'h0000, 16'hffff, 1'b1, 22'd16128},
    '{4'd15, 4'd0, 16'h8000, 16'h8000, 1'b1, 22'd16128},
    '{4'd5, 4'd10, 16'h0123, 16'h0456, 1'b0, 22'd0},
    '{4'd10, 4'd5, 16'h7fff, 16'h0000, 1'b0, 22'd0},
    '{4'd0, 4'd15, 16'h0000, 16'h7fff, 1'b0, 22'd0}
  };

  // Register settings walked in turn: seed, octaves, amplitude, smoothness,
  // offset, roughness.
  typedef logic [31:0] reg_set_t [6];
  reg_set_t settings[] = '{
    '{32'd0, 32'd7, 32'd70, 32'd235, 32'd0, 32'd34734},
    '{32'h7fffffff, 32'd16, 32'd1023, 32'd1, 32'h3ff, 32'd65535},
    '{32'h80000000, 32'd0, 32'd0, 32'd0, 32'h400, 32'd0},
    '{32'hdeadbeef, 32'd1, 32'd512, 32'd65535, 32'h7f0, 32'd20000},
    '{32'h12345678, 32'd31, 32'd1023, 32'd2, 32'h400, 32'd65535},
    '{32'hffffffff, 32'd17, 32'd1, 32'd7, 32'h3ff, 32'd1},
    '{32'h00000001, 32'd4, 32'd300, 32'd64, 32'h000, 32'd40000}
  };

  initial begin
    build_blend_tab();
    sh_seed = RST_SEED;
    sh_octaves = RST_OCTAVES;
    sh_amp = RST_AMPLITUDE;
    sh_smooth = RST_SMOOTHNESS;
    sh_offset = RST_OFFSET;
    sh_rough = RST_ROUGHNESS;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed columns at reset settings, then again at the extreme settings.
    for (int s = 0; s < 3; s++) begin
      if (s > 0) begin
        wait_drained();
        for (int k = 0; k < 6; k++) write_reg(CFG_ADDR_W'(k), settings[s][k]);
      end
      foreach (directed[i]) begin
        if (directed[i].known) begin
          column_res_t want;
          want = column_height(directed[i].lx, directed[i].lz, directed[i].cx,
                               directed[i].cz);
          if (want.height !== directed[i].height) begin
            $display("%0t: table row %0d expected %0d actual %0d", $time, i,
                     directed[i].height, want.height);
            errors++;
          end
        end
        send_column(directed[i].lx, directed[i].lz, directed[i].cx, directed[i].cz);
      end
    end

    // Random columns, mostly inside the world and at small coordinates.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      logic [15:0] cx, cz;
      if (n % 250 == 0) begin
        wait_drained();
        for (int k = 0; k < 6; k++)
          write_reg(CFG_ADDR_W'(k), (n / 250 == 6) ? $urandom() :
                    settings[n / 250][k]);
      end
      if (n >= RAND_ITEMS - 150) calm = 1'b1;
      case ($urandom_range(9))
        0: begin cx = 16'($urandom()); cz = 16'($urandom()); end
        1, 2: begin cx = 16'($urandom_range(0, 32767)); cz = 16'($urandom_range(0, 32767)); end
        default: begin cx = 16'($urandom_range(0, 40)); cz = 16'($urandom_range(0, 40)); end
      endcase
      send_column(4'($urandom()), 4'($urandom()), cx, cz);
    end

    s_axis_tvalid <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Checked %0d result beats, %0d of them outside the world,", results_seen,
             outside_seen);
    $display("over reset, extreme and random register settings.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
